// ===== rtl/core/bdpc_pkg.sv =====
package bdpc_pkg;

    // Width of the quiet and held counters; both saturate at all ones.
    localparam int CNT_W = 16;

    // Width of the two configuration registers and of the write data.
    localparam int REG_W = 16;

    // Compare width that holds both a counter and a register without loss.
    localparam int CMP_W = (CNT_W > REG_W) ? CNT_W : REG_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 1'd1;

    // Register reset values.
    localparam logic [REG_W-1:0] DEBOUNCE_TICKS_RST   = 16'd50;
    localparam logic [REG_W-1:0] LONG_PRESS_TICKS_RST = 16'd3000;

    // Button levels on the active-low pin.
    localparam logic LEVEL_RELEASED = 1'b1;
    localparam logic LEVEL_PRESSED  = 1'b0;

    typedef logic [CNT_W-1:0] t_count;

    // Debouncer state carried from one tick to the next.
    typedef struct packed {
        logic   prev_raw;
        logic   debounced;
        t_count quiet_count;
        t_count held_count;
        logic   long_done;
    } t_state;

    // Per-tick result.
    typedef struct packed {
        logic stable_level;
        logic short_press;
        logic long_press;
    } t_result;

    // Current register settings handed to the update logic.
    typedef struct packed {
        logic [REG_W-1:0] debounce_ticks;
        logic [REG_W-1:0] long_press_ticks;
    } t_cfg;

    // Saturating increment.
    function automatic t_count sat_inc(input t_count v);
        t_count r;
        r = (v == {CNT_W{1'b1}}) ? v : v + t_count'(1);
        return r;
    endfunction

endpackage

// ===== rtl/core/bdpc_tick_if.sv =====
interface bdpc_tick_if;
    logic valid;
    logic ready;
    logic raw_level;

    modport source (output valid, output raw_level, input ready);
    modport sink   (input valid, input raw_level, output ready);
endinterface

// ===== rtl/core/bdpc_res_if.sv =====
interface bdpc_res_if;
    logic valid;
    logic ready;
    logic stable_level;
    logic short_press;
    logic long_press;

    modport source (output valid, output stable_level, output short_press,
                     output long_press, input ready);
    modport sink   (input valid, input stable_level, input short_press,
                     input long_press, output ready);
endinterface

// ===== rtl/core/bdpc_step.sv =====
module bdpc_step (
    input  logic             i_raw,
    input  bdpc_pkg::t_state i_state,
    input  bdpc_pkg::t_cfg   i_cfg,
    output bdpc_pkg::t_state o_state,
    output bdpc_pkg::t_result o_result
);

    // One tick of the debouncer: count, then compare and classify.
    always_comb begin
        bdpc_pkg::t_state n_st;
        logic             n_short;
        logic             n_long;
        n_st    = i_state;
        n_short = 1'b0;
        n_long  = 1'b0;

        // The quiet counter restarts on any raw change.
        if (i_raw != i_state.prev_raw) begin
            n_st.quiet_count = '0;
        end else begin
            n_st.quiet_count = bdpc_pkg::sat_inc(i_state.quiet_count);
        end
        n_st.held_count = bdpc_pkg::sat_inc(i_state.held_count);

        // Only a level that has been quiet long enough is trusted.
        if (bdpc_pkg::CMP_W'(n_st.quiet_count) >
                bdpc_pkg::CMP_W'(i_cfg.debounce_ticks)) begin
            if (i_raw != i_state.debounced) begin
                n_st.debounced = i_raw;
                if (i_raw == bdpc_pkg::LEVEL_PRESSED) begin
                    n_st.held_count = '0;
                    n_st.long_done  = 1'b0;
                end else if (!i_state.long_done &&
                        (bdpc_pkg::CMP_W'(n_st.held_count) <
                         bdpc_pkg::CMP_W'(i_cfg.long_press_ticks))) begin
                    n_short = 1'b1;
                end
            end
            // A hold that reaches the long time fires once per press.
            if ((n_st.debounced == bdpc_pkg::LEVEL_PRESSED) && !n_st.long_done &&
                    (bdpc_pkg::CMP_W'(n_st.held_count) >=
                     bdpc_pkg::CMP_W'(i_cfg.long_press_ticks))) begin
                n_st.long_done = 1'b1;
                n_long         = 1'b1;
            end
        end

        n_st.prev_raw = i_raw;

        o_state                 = n_st;
        o_result.stable_level   = n_st.debounced;
        o_result.short_press    = n_short;
        o_result.long_press     = n_long;
    end

endmodule

// ===== rtl/core/button_debounce_press_classifier_core.sv =====
// Channel   Port    Dir  Payload
// -------   ------  ---  ---------------------------------------------
// tick      i_tick  in   raw_level (1 = released, 0 = pressed)
// result    o_res   out  stable_level, short_press, long_press
// config    i_cfg_* in   i_cfg_we, i_cfg_idx, i_cfg_data (16 bit)
//
// One tick request is taken every cycle while the result is not stalled; its result
// is loaded into the result register once the input register can advance, and is then
// offered on o_res (input register, then result register).
// The state update is a single combinational pass of counter increments and compares
// between the input register and the result register.
// Reset (synchronous, active low) sets the registers to 50 and 3000 and the
// state to released with cleared counters.
// A stalled result holds the result register; the input register then fills
// and the tick request waits.
module button_debounce_press_classifier_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bdpc_pkg::REG_W-1:0]         i_cfg_data,
    bdpc_tick_if.sink                          i_tick,
    bdpc_res_if.source                         o_res
);

    bdpc_pkg::t_cfg    r_cfg;
    bdpc_pkg::t_state  r_st;
    bdpc_pkg::t_state  n_st;
    bdpc_pkg::t_result n_res;
    bdpc_pkg::t_result r_res;
    logic              r_in_valid;
    logic              r_in_raw;
    logic              r_out_valid;
    logic              w_advance;
    logic              w_in_take;

    // The buffered tick moves on when the result register is free or drains.
    assign w_advance    = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_tick.ready = !r_in_valid || w_advance;
    assign w_in_take    = i_tick.valid && i_tick.ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= bdpc_pkg::DEBOUNCE_TICKS_RST;
            r_cfg.long_press_ticks <= bdpc_pkg::LONG_PRESS_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bdpc_pkg::CFG_DEBOUNCE_TICKS:   r_cfg.debounce_ticks   <= i_cfg_data;
                bdpc_pkg::CFG_LONG_PRESS_TICKS: r_cfg.long_press_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state and result for the buffered tick.
    bdpc_step u_step (
        .i_raw    (r_in_raw),
        .i_state  (r_st),
        .i_cfg    (r_cfg),
        .o_state  (n_st),
        .o_result (n_res)
    );

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
            r_st.prev_raw      <= bdpc_pkg::LEVEL_RELEASED;
            r_st.debounced     <= bdpc_pkg::LEVEL_RELEASED;
            r_st.quiet_count   <= '0;
            r_st.held_count    <= '0;
            r_st.long_done     <= 1'b0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_raw <= i_tick.raw_level;
        end
        if (w_advance) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.stable_level = r_res.stable_level;
    assign o_res.short_press  = r_res.short_press;
    assign o_res.long_press   = r_res.long_press;

`ifndef ASSERT_OFF
    // A result is never both a short and a long press.
    a_one_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.short_press && r_res.long_press))
        else $error("short and long press in one result");

    // A short press is reported together with the released level.
    a_short_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.short_press) |->
            (r_res.stable_level == bdpc_pkg::LEVEL_RELEASED))
        else $error("short press while still pressed");

    // A long press is reported while the button is still held.
    a_long_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.long_press) |->
            (r_res.stable_level == bdpc_pkg::LEVEL_PRESSED))
        else $error("long press while released");

    // Setting the long-press mark comes with a long-press result.
    a_long_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_st.long_done) |-> (r_out_valid && r_res.long_press))
        else $error("long-press mark set without a pulse");

    // The state only changes when a tick moves into the result register.
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_st))
        else $error("state changed without a tick");
`endif

endmodule
